// ===== src/u9rl_pkg.sv =====
// Shared types and constants for the 9-bit run-length UART receive decoder.
// Used by u9rl_ctrl, u9rl_dpath and the top level; no dependencies.
`default_nettype none

package u9rl_pkg;

  // Time base: burst time in ticks, bit centers carry 16 fraction bits
  localparam int TIME_W = 32;
  localparam int CTR_W  = TIME_W + 16;

  // Field widths
  localparam int LEN_W  = 15;
  localparam int SKIP_W = 24;
  localparam int PER_W  = 26;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 2;

  localparam logic [PER_W-1:0] PERIOD_RESET = 26'd2275555;

  // Bit index milestones within a character
  localparam logic [IDX_W-1:0] IDX_NINTH = 4'd8;
  localparam logic [IDX_W-1:0] IDX_STOP  = 4'd9;
  localparam logic [IDX_W-1:0] IDX_STOP2 = 4'd10;

  // Most results reported for one input item
  localparam logic [CNT_W-1:0] MAX_RESULTS = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RESCUE = 2'd1;
  localparam logic [1:0] ST_FRAME  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // Source of a result's character fields
  typedef enum logic [1:0] {
    ES_REJECT = 2'd0,
    ES_CHAR   = 2'd1,
    ES_FILL   = 2'd2
  } emit_src_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      skip_sub;
    logic      ctr_hunt;
    logic      ctr_verify;
    logic      ctr_add;
    logic      shift_bit;
    logic      take_ninth;
    logic      set_idx10;
    logic      time_add;
    logic      close;
    logic      emit;
    emit_src_t emit_src;
    logic [1:0] emit_status;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic has_len;
    logic lvl;
    logic last;
    logic skip_fits;
    logic in_win;
    logic idx_lt8;
    logic idx_eq8;
    logic idx_eq9;
    logic idx_eq10;
    logic emit_ok;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/uart9_run_length_rx_decoder.sv =====
// Top level of the 9-bit run-length UART receive decoder.
// Depends on u9rl_pkg, u9rl_ctrl and u9rl_dpath.
//
// Decodes 9-bit UART characters from a stream of line runs (level and length in
// 100 ns ticks) grouped into bursts, sampling each bit at its center with a Q16
// bit period set by cfg_wdata. One run is handled at a time: it is accepted,
// then the decode loop makes one pass per cycle while no result waits on
// m_tready (each sample point that falls in the run, each phase change, and one
// closing pass), then a burst-closing step follows when the run ends a burst.
// The result register lets the next run be accepted while a result is still
// waiting; at most two results are reported per run. Write the period only
// while the block is idle.
`default_nettype none

module uart9_run_length_rx_decoder
  import u9rl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // run input
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [39:0]      s_tdata,   // run_level, run_ticks[14:0], echo_ticks[23:0]
  input  wire logic [0:0]       s_tuser,   // first_of_burst
  input  wire logic             s_tlast,   // last_of_burst
  // character output
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,   // char_data[7:0], addr_bit, 7 zero bits
  output logic [1:0]            m_tuser,   // status
  // bit period register
  input  wire logic             cfg_we,
  input  wire logic [PER_W-1:0] cfg_wdata
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] out_char;
  logic       out_ninth;

  u9rl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_first (s_tuser[0]),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u9rl_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_level   (s_tdata[0]),
    .in_ticks   (s_tdata[15:1]),
    .in_first   (s_tuser[0]),
    .in_last    (s_tlast),
    .in_skip    (s_tdata[39:16]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_char   (out_char),
    .out_ninth  (out_ninth),
    .out_status (m_tuser)
  );

  // Pack result transaction
  assign m_tdata = {7'b0000000, out_ninth, out_char};

`ifndef SYNTHESIS
  // An accepted run blocks further input in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // Results are produced only while a run is in work
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result produced while idle");

  // A start reject carries no character
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_REJECT) |-> (m_tdata[8:0] == 9'd0))
    else $error("start reject with nonzero character");
`endif

endmodule

`default_nettype wire

// ===== src/u9rl_ctrl.sv =====
// Controller for the 9-bit run-length UART receive decoder: sequencer and decode phase.
// Depends on u9rl_pkg; drives u9rl_dpath through cmd_t, reads sts_t back.
`default_nettype none

module u9rl_ctrl
  import u9rl_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_first,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_RUN   = 2'd1,
    SEQ_CLOSE = 2'd2
  } seq_t;

  typedef enum logic [2:0] {
    PH_SKIP     = 3'd0,
    PH_HUNT     = 3'd1,
    PH_VERIFY   = 3'd2,
    PH_SAMPLE   = 3'd3,
    PH_SEEK_END = 3'd4,
    PH_SKIP_LOW = 3'd5
  } phase_t;

  seq_t   state, state_next;
  phase_t phase, phase_next;
  logic   run_done;

  assign in_ready = (state == SEQ_IDLE);

  // Next state and command decode; one pass of the run loop per cycle unless a result waits on the output
  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    run_done   = 1'b0;
    case (state)
      SEQ_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SEQ_RUN;
          if (in_first) begin
            phase_next = PH_SKIP;
          end
        end
      end
      SEQ_RUN: begin
        if (!sts.has_len) begin
          state_next = sts.last ? SEQ_CLOSE : SEQ_IDLE;
        end else begin
          case (phase)
            PH_SKIP: begin
              if (sts.skip_fits) begin
                cmd.skip_sub = 1'b1;
                run_done     = 1'b1;
              end else begin
                phase_next = PH_HUNT;
              end
            end
            PH_SKIP_LOW: begin
              if (!sts.lvl) begin
                run_done = 1'b1;
              end else begin
                phase_next = PH_HUNT;
              end
            end
            PH_VERIFY: begin
              if (!sts.in_win) begin
                run_done = 1'b1;
              end else if (sts.lvl) begin
                // line went high again before mid start bit
                if (sts.emit_ok) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_src    = ES_REJECT;
                  cmd.emit_status = ST_REJECT;
                  phase_next      = PH_HUNT;
                end
              end else begin
                cmd.ctr_verify = 1'b1;
                phase_next     = PH_SAMPLE;
              end
            end
            PH_SAMPLE: begin
              if (!sts.in_win) begin
                run_done = 1'b1;
              end else if (sts.idx_lt8) begin
                cmd.shift_bit = 1'b1;
                cmd.ctr_add   = 1'b1;
              end else if (sts.idx_eq8) begin
                cmd.take_ninth = 1'b1;
                cmd.ctr_add    = 1'b1;
              end else if (sts.idx_eq9) begin
                if (sts.lvl) begin
                  if (sts.emit_ok) begin
                    cmd.ctr_add     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_src    = ES_CHAR;
                    cmd.emit_status = ST_OK;
                    phase_next      = PH_SEEK_END;
                  end
                end else begin
                  cmd.ctr_add   = 1'b1;
                  cmd.set_idx10 = 1'b1;
                end
              end else begin
                // second stop bit: rescue or framing error
                if (sts.emit_ok) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_src    = ES_CHAR;
                  cmd.emit_status = sts.lvl ? ST_RESCUE : ST_FRAME;
                  phase_next      = sts.lvl ? PH_SEEK_END : PH_SKIP_LOW;
                end
              end
            end
            PH_SEEK_END: begin
              if (!sts.in_win) begin
                run_done = 1'b1;
              end else begin
                phase_next = PH_HUNT;
              end
            end
            default: begin
              // start bit search
              if (sts.lvl) begin
                phase_next = PH_HUNT;
                run_done   = 1'b1;
              end else begin
                cmd.ctr_hunt = 1'b1;
                phase_next   = PH_VERIFY;
              end
            end
          endcase
          if (run_done) begin
            cmd.time_add = 1'b1;
            state_next   = sts.last ? SEQ_CLOSE : SEQ_IDLE;
          end
        end
      end
      SEQ_CLOSE: begin
        // burst end: flush a pending character with idle-high samples, or reject a start still in verify
        if (phase == PH_VERIFY) begin
          if (sts.emit_ok) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = ES_REJECT;
            cmd.emit_status = ST_REJECT;
            cmd.close       = 1'b1;
            phase_next      = PH_SKIP;
            state_next      = SEQ_IDLE;
          end
        end else if (phase == PH_SAMPLE) begin
          if (sts.emit_ok) begin
            cmd.emit        = 1'b1;
            cmd.emit_src    = ES_FILL;
            cmd.emit_status = sts.idx_eq10 ? ST_RESCUE : ST_OK;
            cmd.close       = 1'b1;
            phase_next      = PH_SKIP;
            state_next      = SEQ_IDLE;
          end
        end else begin
          cmd.close  = 1'b1;
          phase_next = PH_SKIP;
          state_next = SEQ_IDLE;
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      phase <= PH_SKIP;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/u9rl_dpath.sv =====
// Datapath for the 9-bit run-length UART receive decoder: time, bit centers, shifter, result reg.
// Depends on u9rl_pkg; controlled by u9rl_ctrl through cmd_t.
`default_nettype none

module u9rl_dpath
  import u9rl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic              in_level,
  input  wire logic [LEN_W-1:0]  in_ticks,
  input  wire logic              in_first,
  input  wire logic              in_last,
  input  wire logic [SKIP_W-1:0] in_skip,
  input  wire logic              cfg_we,
  input  wire logic [PER_W-1:0]  cfg_wdata,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [7:0]             out_char,
  output logic                   out_ninth,
  output logic [1:0]             out_status
);

  logic [PER_W-1:0]  period;
  logic              lvl_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;
  logic [TIME_W-1:0] burst_time;
  logic [SKIP_W-1:0] skip_left;
  logic [CTR_W-1:0]  center;
  logic [IDX_W-1:0]  bit_index;
  logic [7:0]        data_shift;
  logic              ninth;
  logic [CNT_W-1:0]  emit_cnt;

  logic [PER_W:0]    verify_step;
  logic [TIME_W-1:0] offset;
  logic [7:0]        fill_data;
  logic              fill_ninth;
  logic              cnt_full;
  logic              push;

  // First center after start: +1 period, +half period minus its whole ticks
  assign verify_step = {1'b0, period} + {{(PER_W-15){1'b0}}, period[16:1]};

  // Distance of the current sample point from the run start
  assign offset = center[CTR_W-1:16] - burst_time;

  // Idle-high fill of unsampled bits at burst end
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fill_data[i] = data_shift[i] | (IDX_W'(i) >= bit_index);
    end
    fill_ninth = (bit_index <= IDX_NINTH) ? 1'b1 : ninth;
  end

  assign cnt_full = (emit_cnt == MAX_RESULTS);
  assign push     = cmd.emit && !cnt_full;

  // Status to controller
  always_comb begin
    sts           = '0;
    sts.has_len   = (len_q != '0);
    sts.lvl       = lvl_q;
    sts.last      = last_q;
    sts.skip_fits = ({{(SKIP_W-LEN_W){1'b0}}, len_q} <= skip_left);
    sts.in_win    = (offset < {{(TIME_W-LEN_W){1'b0}}, len_q});
    sts.idx_lt8   = (bit_index < IDX_NINTH);
    sts.idx_eq8   = (bit_index == IDX_NINTH);
    sts.idx_eq9   = (bit_index == IDX_STOP);
    sts.idx_eq10  = (bit_index == IDX_STOP2);
    sts.emit_ok   = !out_valid || out_ready || cnt_full;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lvl_q  <= in_level;
      len_q  <= in_ticks;
      last_q <= in_last;
    end
  end

  // Decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_time <= '0;
      skip_left  <= '0;
      center     <= '0;
      bit_index  <= '0;
      data_shift <= '0;
      ninth      <= 1'b0;
      emit_cnt   <= '0;
    end else begin
      if (cmd.load) begin
        emit_cnt <= '0;
        if (in_first) begin
          burst_time <= '0;
          skip_left  <= in_skip;
          bit_index  <= '0;
          data_shift <= '0;
          ninth      <= 1'b0;
        end
      end
      if (push) begin
        emit_cnt <= emit_cnt + 1'b1;
      end
      if (cmd.skip_sub) begin
        skip_left <= skip_left - {{(SKIP_W-LEN_W){1'b0}}, len_q};
      end
      if (cmd.time_add) begin
        burst_time <= burst_time + {{(TIME_W-LEN_W){1'b0}}, len_q};
      end
      // bit center arithmetic
      if (cmd.ctr_hunt) begin
        center <= {burst_time + {{(TIME_W-(PER_W-17)){1'b0}}, period[PER_W-1:17]}, 16'h0000};
      end else if (cmd.ctr_verify) begin
        center <= center + {{(CTR_W-PER_W-1){1'b0}}, verify_step};
      end else if (cmd.ctr_add) begin
        center <= center + {{(CTR_W-PER_W){1'b0}}, period};
      end
      // character assembly
      if (cmd.ctr_verify) begin
        bit_index  <= '0;
        data_shift <= '0;
        ninth      <= 1'b0;
      end else if (cmd.shift_bit) begin
        data_shift[bit_index[2:0]] <= lvl_q;
        bit_index                  <= bit_index + 1'b1;
      end else if (cmd.take_ninth) begin
        ninth     <= lvl_q;
        bit_index <= IDX_STOP;
      end else if (cmd.set_idx10) begin
        bit_index <= IDX_STOP2;
      end
      if (cmd.close) begin
        data_shift <= fill_data;
        ninth      <= fill_ninth;
        skip_left  <= '0;
        burst_time <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_status <= cmd.emit_status;
      case (cmd.emit_src)
        ES_CHAR: begin
          out_char  <= data_shift;
          out_ninth <= ninth;
        end
        ES_FILL: begin
          out_char  <= fill_data;
          out_ninth <= fill_ninth;
        end
        default: begin
          out_char  <= '0;
          out_ninth <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
